// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the rtl top, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define IBS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition now implies a consequence in the next cycle
`define IBS_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/ibs_pkg.sv
// ----------------------------------------------------------------------------
// ibs_pkg
// shared types and constants of the indirect binary search block
// ----------------------------------------------------------------------------
package ibs_pkg;

	localparam int DEPTH     = 256;
	localparam int KEY_WIDTH = 32;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CFG_IDX_W = 2;

	// commands
	localparam logic [1:0] CMD_WRITE_KEY   = 2'd0;
	localparam logic [1:0] CMD_WRITE_ORDER = 2'd1;
	localparam logic [1:0] CMD_SEARCH      = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIGNED  = 2'd1;

	localparam logic [KEY_WIDTH-1:0] KEY_SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  slot;
		logic [31:0] key_value;
		logic [7:0]  order_entry;
		logic [31:0] search_key;
	} req_t;

	typedef struct packed {
		logic [8:0] position;
		logic       found;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ord_port_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [KEY_WIDTH-1:0] wdata;
		logic                 re;
		logic [ADDR_W-1:0]    raddr;
	} key_port_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_KEY,
		S_CMP
	} state_t;

endpackage

// File: rtl/ibs_ram.sv
// ----------------------------------------------------------------------------
// ibs_ram
// simple dual port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ibs_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/ibs_ctrl.sv
// ----------------------------------------------------------------------------
// ibs_ctrl
// command decode and search sequencer driving the order and key stores
// ----------------------------------------------------------------------------
module ibs_ctrl import ibs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	input  logic [CNT_W-1:0]     n_eff,
	input  logic                 key_signed,
	input  logic                 out_free,
	output ord_port_t            ord_port,
	input  logic [ADDR_W-1:0]    ord_rdata,
	output key_port_t            key_port,
	input  logic [KEY_WIDTH-1:0] key_rdata,
	output logic                 res_valid,
	output rsp_t                 res
);

	state_t               state_q, state_d;
	logic [ADDR_W-1:0]    l_q, l_d;
	logic [ADDR_W-1:0]    r_q, r_d;
	logic [ADDR_W-1:0]    mid_q, mid_d;
	logic [KEY_WIDTH-1:0] want_q, want_d;
	logic [CNT_W-1:0]     n_q, n_d;

	logic                 accept;
	logic                 zero_search;
	logic [KEY_WIDTH-1:0] sign_mask;
	logic [KEY_WIDTH-1:0] have;
	logic [ADDR_W-1:0]    r_init;

	assign sign_mask   = key_signed ? KEY_SIGN : '0;
	assign have        = key_rdata ^ sign_mask;
	assign zero_search = (req.command == CMD_SEARCH) && (n_eff == '0);
	assign r_init      = ADDR_W'(n_eff - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		l_q    <= l_d;
		r_q    <= r_d;
		mid_q  <= mid_d;
		want_q <= want_d;
		n_q    <= n_d;
	end

	always_comb begin
		state_d   = state_q;
		l_d       = l_q;
		r_d       = r_q;
		mid_d     = mid_q;
		want_d    = want_q;
		n_d       = n_q;
		req_stall = 1'b1;
		accept    = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		ord_port       = '0;
		ord_port.waddr = req.slot[ADDR_W-1:0];
		ord_port.wdata = req.order_entry[ADDR_W-1:0];
		key_port       = '0;
		key_port.waddr = req.slot[ADDR_W-1:0];
		key_port.wdata = req.key_value[KEY_WIDTH-1:0];

		unique case (state_q)
			S_IDLE: begin
				req_stall = zero_search && !out_free;
				accept    = req_valid && !req_stall;
				if (accept) begin
					unique case (req.command)
						CMD_WRITE_KEY:   key_port.we = 1'b1;
						CMD_WRITE_ORDER: ord_port.we = 1'b1;
						CMD_SEARCH: begin
							if (n_eff == '0) begin
								res_valid = 1'b1;
							end else begin
								l_d            = '0;
								r_d            = r_init;
								mid_d          = r_init >> 1;
								want_d         = req.search_key[KEY_WIDTH-1:0] ^ sign_mask;
								n_d            = n_eff;
								ord_port.re    = 1'b1;
								ord_port.raddr = r_init >> 1;
								state_d        = S_KEY;
							end
						end
						default: ;
					endcase
				end
			end
			S_KEY: begin
				key_port.re    = 1'b1;
				key_port.raddr = ord_rdata;
				state_d        = S_CMP;
			end
			S_CMP: begin
				priority if (have == want_q) begin
					if (out_free) begin
						res_valid    = 1'b1;
						res.position = CNT_W'(mid_q);
						res.found    = 1'b1;
						state_d      = S_IDLE;
					end
				end else if ((have < want_q) ? (mid_q == r_q) : (mid_q == l_q)) begin
					// bounds cross: key absent
					if (out_free) begin
						res_valid    = 1'b1;
						res.position = n_q;
						state_d      = S_IDLE;
					end
				end else begin
					if (have < want_q) begin
						l_d = mid_q + ADDR_W'(1);
					end else begin
						r_d = mid_q - ADDR_W'(1);
					end
					mid_d          = l_d + ((r_d - l_d) >> 1);
					ord_port.re    = 1'b1;
					ord_port.raddr = mid_d;
					state_d        = S_KEY;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: rtl/indirect_binary_search_top.sv
// ----------------------------------------------------------------------------
// indirect_binary_search_top
// binary search over a key store through an order store of key slots
// ----------------------------------------------------------------------------
// writes are taken whenever the sequencer is idle; a search probes until the key is found or the bounds cross
// each probe is an order store read followed by a key store read
// the result shows on rsp in the cycle after the last compare, when the next item can be taken
// a search with zero entries answers in the cycle after it is accepted
// arst_n clears the sequencer, the result valid and the config registers;
//   the stores are not cleared and hold nothing useful until written
module indirect_binary_search_top import ibs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	// result items
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

`include "assert_macros.svh"

	// configuration registers
	logic [CNT_W-1:0] entry_count_q;
	logic             key_signed_q;
	logic [CNT_W-1:0] n_eff;

	// result register
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             out_free;

	// sequencer to store and result wiring
	ord_port_t            ord_port;
	key_port_t            key_port;
	logic [ADDR_W-1:0]    ord_rdata;
	logic [KEY_WIDTH-1:0] key_rdata;
	logic                 res_valid;
	rsp_t                 res;

	// config is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			key_signed_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENTRY_COUNT: entry_count_q <= cfg_data;
				CFG_KEY_SIGNED:  key_signed_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// counts above the store depth act as a full store
	assign n_eff = (entry_count_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : entry_count_q;

	// output register: may load when empty or being taken this cycle
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// order store: order position -> key slot
	ibs_ram #(
		.WIDTH  (ADDR_W),
		.ADDR_W (ADDR_W)
	) u_order_ram (
		.clk   (clk),
		.we    (ord_port.we),
		.waddr (ord_port.waddr),
		.wdata (ord_port.wdata),
		.re    (ord_port.re),
		.raddr (ord_port.raddr),
		.rdata (ord_rdata)
	);

	// key store: key slot -> key
	ibs_ram #(
		.WIDTH  (KEY_WIDTH),
		.ADDR_W (ADDR_W)
	) u_key_ram (
		.clk   (clk),
		.we    (key_port.we),
		.waddr (key_port.waddr),
		.wdata (key_port.wdata),
		.re    (key_port.re),
		.raddr (key_port.raddr),
		.rdata (key_rdata)
	);

	// decode and probe sequencer
	ibs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.n_eff      (n_eff),
		.key_signed (key_signed_q),
		.out_free   (out_free),
		.ord_port   (ord_port),
		.ord_rdata  (ord_rdata),
		.key_port   (key_port),
		.key_rdata  (key_rdata),
		.res_valid  (res_valid),
		.res        (res)
	);

	// helpers for the checks below
	logic search_acc;
	assign search_acc = req_valid && !req_stall && (req.command == CMD_SEARCH);

	// the sequencer only finishes a search when the result register can take it
	`IBS_ASSERT(a_res_room, res_valid |-> out_free, "result produced with no room")
	// a search over a non-empty store holds off the next item
	`IBS_ASSERT_NEXT(a_busy_stall, search_acc && (n_eff != '0), req_stall, "item taken mid search")
	// an empty store answers at once with position zero, not found
	`IBS_ASSERT_NEXT(a_zero_search, search_acc && (n_eff == '0),
		rsp_valid && (rsp.position == '0) && !rsp.found, "empty search not answered")

endmodule

// File: dv/ibs_checker.sv
// ----------------------------------------------------------------------------
// ibs_checker
// watches the item, result and register channels of the indirect binary
// search block, predicts each search result and compares it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ibs_checker import ibs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rsp_t                 rsp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   results_due
);

	logic [KEY_WIDTH-1:0] key_mem [DEPTH];
	logic [ADDR_W-1:0]    ord_mem [DEPTH];
	logic [CNT_W-1:0]     entry_count;
	logic                 key_signed;
	rsp_t                 search_results [$];
	rsp_t                 oldest;

	// probe sequence of the block, keys mapped so unsigned order gives the chosen order
	function automatic rsp_t search_outcome(input logic [KEY_WIDTH-1:0] look_for);
		int                   n;
		int                   lo;
		int                   hi;
		int                   mid;
		logic [KEY_WIDTH-1:0] want;
		logic [KEY_WIDTH-1:0] have;
		rsp_t                 r;
		n = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
		want = look_for ^ (key_signed ? KEY_SIGN : '0);
		lo = 0;
		hi = n - 1;
		r.position = 9'(n);
		r.found = 1'b0;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			have = key_mem[ord_mem[mid]] ^ (key_signed ? KEY_SIGN : '0);
			if (have == want) begin
				r.position = 9'(mid);
				r.found = 1'b1;
				break;
			end
			if (have < want)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return r;
	endfunction

	// sampled at the falling edge: handshakes seen here complete at the next rising edge
	always @(negedge clk) begin
		if (!arst_n) begin
			entry_count = '0;
			key_signed = 1'b0;
			search_results.delete();
			mismatch_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (search_results.size() == 0) begin
					$error("unexpected result item: position %0d found %0b",
						rsp.position, rsp.found);
					mismatch_count++;
				end else begin
					oldest = search_results.pop_front();
					if (rsp.position !== oldest.position) begin
						$error("position: expected %0d, actual %0d",
							oldest.position, rsp.position);
						mismatch_count++;
					end
					if (rsp.found !== oldest.found) begin
						$error("found: expected %0b, actual %0b", oldest.found, rsp.found);
						mismatch_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				case (req.command)
					CMD_WRITE_KEY:   key_mem[req.slot] = req.key_value;
					CMD_WRITE_ORDER: ord_mem[req.slot] = req.order_entry;
					CMD_SEARCH:      search_results.push_back(search_outcome(req.search_key));
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ENTRY_COUNT: entry_count = cfg_data;
					CFG_KEY_SIGNED:  key_signed = cfg_data[0];
					default: ;
				endcase
			end
		end
		results_due = search_results.size();
	end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// builds sorted key tables through key and order writes, sets entry count
// and key signedness between phases, and fires searches that hit, miss and
// land beside stored keys; the checker beside the block does the predicting
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top import ibs_pkg::*; ();

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// drain time before register writes, longer than the longest search
	localparam int DRAIN_CYCLES   = 24;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEM_TARGET    = 1900;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;
	int                   mismatch_count;
	int                   results_due;

	// what the stimulus side has written, so searches only touch written entries
	logic [KEY_WIDTH-1:0] gen_key [DEPTH];
	bit                   key_ok [DEPTH];
	logic [ADDR_W-1:0]    gen_ord [DEPTH];
	bit                   ord_ok [DEPTH];
	int                   cur_count = 0;
	bit                   cur_signed = 1'b0;
	bit                   calm = 1'b0;       // no gaps and no stalls while set
	int                   items_sent = 0;
	int                   stall_run = 0;
	int                   quiet_cycles = 0;

	indirect_binary_search_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ibs_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run length of an idle stretch: mostly short, now and then long
	function automatic int rand_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 12);
		if (r < 99)
			return $urandom_range(13, 40);
		return $urandom_range(60, 150);
	endfunction

	function automatic int idle_len();
		if (calm || $urandom_range(0, 99) < 50)
			return 0;
		return rand_span();
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		if (calm) begin
			rsp_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			rsp_stall <= 1'b1;
			stall_run <= rand_span();
		end else begin
			rsp_stall <= 1'b0;
			stall_run <= $urandom_range(0, 6);
		end
	end

	// watchdog: any accepted item, taken result or register write restarts the count
	always @(negedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// unused fields carry random bits too
	function automatic req_t random_item();
		req_t it;
		it.command = 2'($urandom);
		it.slot = 8'($urandom);
		it.key_value = $urandom;
		it.order_entry = 8'($urandom);
		it.search_key = $urandom;
		return it;
	endfunction

	// called at a rising edge; returns at the edge where the item is taken
	task automatic push_item(input req_t it);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(negedge clk); while (req_stall);
		@(posedge clk);
		if (it.command != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic write_key(input logic [ADDR_W-1:0] s, input logic [KEY_WIDTH-1:0] k);
		req_t it;
		it = random_item();
		it.command = CMD_WRITE_KEY;
		it.slot = s;
		it.key_value = k;
		gen_key[s] = k;
		key_ok[s] = 1'b1;
		push_item(it);
	endtask

	task automatic write_order(input logic [ADDR_W-1:0] p, input logic [ADDR_W-1:0] s);
		req_t it;
		it = random_item();
		it.command = CMD_WRITE_ORDER;
		it.slot = p;
		it.order_entry = s;
		gen_ord[p] = s;
		ord_ok[p] = 1'b1;
		push_item(it);
	endtask

	task automatic search_for(input logic [KEY_WIDTH-1:0] k);
		req_t it;
		it = random_item();
		it.command = CMD_SEARCH;
		it.search_key = k;
		push_item(it);
	endtask

	task automatic send_unused();
		req_t it;
		it = random_item();
		it.command = CMD_UNUSED;
		push_item(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// registers change only once every search has answered and writes have drained
	task automatic configure(input int n, input bit sgn);
		req_valid <= 1'b0;
		while (results_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_ENTRY_COUNT, 9'(n));
		write_reg(CFG_KEY_SIGNED, 9'(sgn));
		cfg_valid <= 1'b0;
		cur_count = n;
		cur_signed = sgn;
	endtask

	function automatic int active_count();
		return (cur_count > DEPTH) ? DEPTH : cur_count;
	endfunction

	// every probe a search of n entries can make reads only written entries
	function automatic bit table_ready(input int n);
		for (int p = 0; p < n; p++)
			if (!ord_ok[p] || !key_ok[gen_ord[p]])
				return 1'b0;
		return 1'b1;
	endfunction

	// n keys at distinct random slots, order entries ranking them in the chosen order;
	// narrow keys crowd together so duplicates and neighbors show up
	task automatic build_table(input int n, input bit sgn, input bit narrow);
		int                   perm [DEPTH];
		logic [KEY_WIDTH-1:0] ranks [DEPTH];
		logic [KEY_WIDTH-1:0] base;
		logic [KEY_WIDTH-1:0] tmp;
		int                   j;
		int                   t;
		for (int i = 0; i < DEPTH; i++)
			perm[i] = i;
		for (int i = DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		base = $urandom;
		for (int i = 0; i < n; i++)
			ranks[i] = narrow ? base + KEY_WIDTH'($urandom_range(0, n)) : $urandom;
		for (int i = 1; i < n; i++) begin
			tmp = ranks[i];
			j = i - 1;
			while (j >= 0 && ranks[j] > tmp) begin
				ranks[j + 1] = ranks[j];
				j--;
			end
			ranks[j + 1] = tmp;
		end
		for (int i = 0; i < n; i++) begin
			write_key(8'(perm[i]), ranks[i] ^ (sgn ? KEY_SIGN : '0));
			write_order(8'(i), 8'(perm[i]));
		end
	endtask

	// stored keys, their neighbors, random keys and the corners of the key range
	function automatic logic [KEY_WIDTH-1:0] pick_search_key();
		int                   n;
		int                   r;
		logic [KEY_WIDTH-1:0] k;
		n = active_count();
		r = $urandom_range(0, 99);
		if (n > 0 && r < 70) begin
			k = gen_key[gen_ord[$urandom_range(0, n - 1)]];
			if (r >= 50)
				k = r[0] ? k + 1 : k - 1;
			return k;
		end
		if (r < 85)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return KEY_SIGN;
			default: return ~KEY_SIGN;
		endcase
	endfunction

	// ignored commands, overwritten keys and reshuffled order entries
	task automatic send_noise();
		int                n;
		logic [ADDR_W-1:0] s;
		n = active_count();
		case ($urandom_range(0, 3))
			0: send_unused();
			1: write_key(8'($urandom), $urandom);
			2: begin
				s = 8'($urandom);
				if (key_ok[s])
					write_order(8'($urandom), s);
				else
					send_unused();
			end
			default: begin
				if (n > 0)
					write_key(gen_ord[$urandom_range(0, n - 1)], $urandom);
				else
					send_unused();
			end
		endcase
	endtask

	task automatic run_phase(input int n, input bit sgn, input int searches);
		int n_eff;
		configure(n, sgn);
		n_eff = active_count();
		// tables of up to 64 entries are rebuilt sorted, larger ones only when not yet complete
		if (n_eff <= 64 || !table_ready(n_eff))
			build_table(n_eff, sgn, $urandom_range(0, 2) == 0);
		repeat (searches) begin
			if ($urandom_range(0, 99) < 12)
				send_noise();
			else
				search_for(pick_search_key());
		end
	endtask

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		if (r < 75)
			return $urandom_range(1, 16);
		if (r < 88)
			return $urandom_range(17, 64);
		if (r < 92)
			return $urandom_range(65, 200);
		if (r < 97)
			return DEPTH;
		return $urandom_range(DEPTH + 1, 511);
	endfunction

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero entries answers at once, unused command gives nothing back
		configure(0, 1'b0);
		search_for('1);
		send_unused();

		// the four corner keys, ranked unsigned
		write_key(8'd0, '0);
		write_key(8'd127, ~KEY_SIGN);
		write_key(8'd128, KEY_SIGN);
		write_key(8'd255, '1);
		write_order(8'd0, 8'd0);
		write_order(8'd1, 8'd127);
		write_order(8'd2, 8'd128);
		write_order(8'd3, 8'd255);
		configure(4, 1'b0);
		search_for('0);
		search_for(~KEY_SIGN);
		search_for(KEY_SIGN);
		search_for('1);
		search_for(32'd5);

		// same keys ranked as two's complement
		configure(4, 1'b1);
		write_order(8'd0, 8'd128);
		write_order(8'd1, 8'd255);
		write_order(8'd2, 8'd0);
		write_order(8'd3, 8'd127);
		search_for(KEY_SIGN);
		search_for(~KEY_SIGN);
		search_for(32'd1);

		// single entry, key past it
		configure(1, 1'b1);
		search_for('1);

		// full table, then a count beyond the store and the other key order
		run_phase(DEPTH, 1'b1, 30);
		run_phase(511, 1'b1, 15);
		run_phase(DEPTH, 1'b0, 15);

		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			run_phase(pick_count(), $urandom_range(0, 1), $urandom_range(4, 24));
		end

		calm = 1'b0;
		req_valid <= 1'b0;
		while (results_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: indirect_binary_search_top.f
+incdir+rtl
rtl/ibs_pkg.sv
rtl/ibs_ram.sv
rtl/ibs_ctrl.sv
rtl/indirect_binary_search_top.sv
dv/ibs_checker.sv
dv/tb_top.sv
